@@ rtl/core/fdfm_pkg.sv @@
// Package for the dual fan failover monitor.
// Holds the build constants, item kind codes and the per-fan command and status types.
// No dependencies.
package fdfm_pkg;

   localparam int NUM_FANS    = 2;
   localparam int COUNT_WIDTH = 16;
   localparam int LAST_WIDTH  = 16;
   localparam int KIND_WIDTH  = 3;

   localparam logic [KIND_WIDTH-1:0] KIND_PULSE  = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_TICK   = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_SWITCH = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_CLEAR  = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_STATUS = 3'd4;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [LAST_WIDTH-1:0]  last_type;

   typedef struct packed {
      logic pulse;
      logic tick;
      logic switch_drv;
      logic clear;
      logic use_main;
      logic running;
   } fan_cmd_type;

   typedef struct packed {
      logic     spinning;
      logic     failing;
      logic     on_main;
      last_type last;
   } fan_stat_type;

   function automatic last_type to_last(input count_type count);
      logic [31:0] wide;
      wide = 32'(count);
      return wide[LAST_WIDTH-1:0];
   endfunction

endpackage

@@ rtl/core/dual_fan_failover_monitor_top.sv @@
// Each accepted word loads the single response register, which frees as it is taken.
// Throughput: one word per cycle, or none while a held response waits on rsp_ready.
// The state update and the status are one pass of logic from the request ports.
// Reset (synchronous, active high): counts and flags clear, drivers on main,
// monitoring running, second fan disabled, no response pending.
module dual_fan_failover_monitor_top
   import fdfm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [KIND_WIDTH-1:0] req_kind,
   input  logic                  req_fan_index,
   input  logic                  req_fan0_use_main,
   input  logic                  req_fan1_use_main,
   input  logic                  req_run_mode,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_monitor_running,
   output logic                  rsp_fan0_spinning,
   output logic                  rsp_fan0_failing,
   output logic                  rsp_fan0_on_main,
   output logic                  rsp_fan1_spinning,
   output logic                  rsp_fan1_failing,
   output logic                  rsp_fan1_on_main,
   output logic [LAST_WIDTH-1:0] rsp_fan0_last_pulses,
   output logic [LAST_WIDTH-1:0] rsp_fan1_last_pulses
);

   logic         fan1_en_ff;
   logic         run_ff, run_in;
   logic         valid_ff;
   logic         accept;
   logic         fan_active [2];
   fan_cmd_type  cmd [2];
   fan_stat_type stat [2];
   logic         running_o_ff;
   fan_stat_type stat_o_ff [2];

   assign req_ready = !valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign fan_active[0] = 1'b1;
   assign fan_active[1] = fan1_en_ff && (NUM_FANS > 1);

   always_comb begin
      run_in = run_ff;
      if (accept && req_kind == KIND_SWITCH) begin
         run_in = req_run_mode;
      end
   end

   for (genvar i = 0; i < 2; i++) begin : g_fan
      always_comb begin
         cmd[i].pulse      = accept && req_kind == KIND_PULSE && req_fan_index == 1'(i);
         cmd[i].tick       = accept && req_kind == KIND_TICK;
         cmd[i].switch_drv = accept && req_kind == KIND_SWITCH;
         cmd[i].clear      = accept && req_kind == KIND_CLEAR;
         cmd[i].use_main   = (i == 0) ? req_fan0_use_main : req_fan1_use_main;
         cmd[i].running    = run_ff;
      end
      if (i < NUM_FANS) begin : g_on
         fdfm_fan u_fan (
            .clock  (clock),
            .reset  (reset),
            .active (fan_active[i]),
            .cmd    (cmd[i]),
            .stat   (stat[i])
         );
      end else begin : g_off
         assign stat[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fan1_en_ff <= 1'b0;
         run_ff     <= 1'b1;
         valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            fan1_en_ff <= csr_wr_data;
         end
         run_ff <= run_in;
         if (accept) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         running_o_ff <= run_in;
         stat_o_ff[0] <= stat[0];
         stat_o_ff[1] <= stat[1];
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_monitor_running  = running_o_ff;
   assign rsp_fan0_spinning    = stat_o_ff[0].spinning;
   assign rsp_fan0_failing     = stat_o_ff[0].failing;
   assign rsp_fan0_on_main     = stat_o_ff[0].on_main;
   assign rsp_fan0_last_pulses = stat_o_ff[0].last;
   assign rsp_fan1_last_pulses = stat_o_ff[1].last;

   logic fan1_shown_ff;
   always_ff @(posedge clock) begin
      if (accept) begin
         fan1_shown_ff <= fan_active[1];
      end
   end

   assign rsp_fan1_spinning = fan1_shown_ff && stat_o_ff[1].spinning;
   assign rsp_fan1_failing  = fan1_shown_ff && stat_o_ff[1].failing;
   assign rsp_fan1_on_main  = fan1_shown_ff && stat_o_ff[1].on_main;

endmodule

@@ rtl/core/fdfm_fan.sv @@
// One fan channel of the failover monitor: pulse count, latched count, driver and spin flag.
// Reports the status that follows the current command. Depends on fdfm_pkg.
module fdfm_fan
   import fdfm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         active,
   input  fan_cmd_type  cmd,
   output fan_stat_type stat
);

   count_type pulse_ff, pulse_in;
   count_type latch_ff, latch_in;
   logic      main_ff, main_in;
   logic      spin_ff, spin_in;

   always_comb begin
      pulse_in = pulse_ff;
      latch_in = latch_ff;
      main_in  = main_ff;
      spin_in  = spin_ff;
      if (cmd.pulse) begin
         if (pulse_ff != {COUNT_WIDTH{1'b1}}) begin
            pulse_in = pulse_ff + 1'b1;
         end
      end
      if (active && cmd.tick) begin
         if (pulse_ff == '0 && cmd.running) begin
            main_in = !main_ff;
            spin_in = 1'b0;
         end else begin
            latch_in = pulse_ff;
            spin_in  = 1'b1;
            pulse_in = '0;
         end
      end
      if (active && cmd.switch_drv) begin
         main_in = cmd.use_main;
      end
      if (active && cmd.clear) begin
         pulse_in = '0;
         latch_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff <= '0;
         latch_ff <= '0;
         main_ff  <= 1'b1;
         spin_ff  <= 1'b0;
      end else begin
         pulse_ff <= pulse_in;
         latch_ff <= latch_in;
         main_ff  <= main_in;
         spin_ff  <= spin_in;
      end
   end

   assign stat.spinning = spin_in;
   assign stat.failing  = (pulse_in == '0) && (latch_in == '0);
   assign stat.on_main  = main_in;
   assign stat.last     = to_last(latch_in);

endmodule

@@ rtl/core/fdfm_checker.sv @@
// Port-level checks for the dual fan failover monitor, bound to the top level.
// Depends on fdfm_pkg and dual_fan_failover_monitor_top.
module fdfm_checker
   import fdfm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [KIND_WIDTH-1:0] req_kind,
   input logic                  req_run_mode,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_monitor_running,
   input logic                  rsp_fan0_spinning,
   input logic                  rsp_fan0_failing,
   input logic                  rsp_fan0_on_main,
   input logic                  rsp_fan1_spinning,
   input logic                  rsp_fan1_failing,
   input logic                  rsp_fan1_on_main,
   input logic [LAST_WIDTH-1:0] rsp_fan0_last_pulses,
   input logic [LAST_WIDTH-1:0] rsp_fan1_last_pulses
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_monitor_running)
         && $stable(rsp_fan0_spinning) && $stable(rsp_fan0_failing)
         && $stable(rsp_fan0_on_main) && $stable(rsp_fan1_spinning)
         && $stable(rsp_fan1_failing) && $stable(rsp_fan1_on_main)
         && $stable(rsp_fan0_last_pulses) && $stable(rsp_fan1_last_pulses))
      else $error("response word changed while stalled");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request word gave no response word");

   a_switch_run: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_SWITCH
         |=> rsp_monitor_running == $past(req_run_mode))
      else $error("switch word did not set running flag");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fan0_failing |-> rsp_fan0_last_pulses == '0)
      else $error("fan 0 failing with nonzero latched count");

endmodule

bind dual_fan_failover_monitor_top fdfm_checker u_fdfm_checker (.*);
